// File: rtl/core/li_pkg.sv
// shared types, operation codes and double-precision helpers of the interpolator
package li_pkg;

  localparam int MAX_POINTS_DEF = 16;

  localparam logic [1:0] FOP_ADD = 2'd0;
  localparam logic [1:0] FOP_SUB = 2'd1;
  localparam logic [1:0] FOP_MUL = 2'd2;
  localparam logic [1:0] FOP_DIV = 2'd3;

  localparam logic [63:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_DNAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] DBL_QBIT = 64'h0008_0000_0000_0000;

  typedef struct packed {
    logic        is_eval;
    logic [3:0]  slot;
    logic [63:0] vx;
    logic [63:0] vy;
    logic        eob;
  } li_item_t;

  typedef struct packed {
    logic        go;
    logic [1:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } fp_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fp_rsp_t;

  typedef struct packed {
    logic               s;
    logic               zero;
    logic               inf;
    logic               nan;
    logic signed [15:0] e;
    logic [52:0]        m;
  } fp_unp_t;

  // value = m * 2^e, subnormals keep their unnormalized mantissa
  function automatic fp_unp_t fp_unpack(input logic [63:0] v);
    fp_unp_t u;
    u.s    = v[63];
    u.zero = (v[62:52] == 11'd0) && (v[51:0] == 52'd0);
    u.inf  = (&v[62:52]) && (v[51:0] == 52'd0);
    u.nan  = (&v[62:52]) && (|v[51:0]);
    if (v[62:52] == 11'd0) begin
      u.m = {1'b0, v[51:0]};
      u.e = -16'sd1074;
    end else begin
      u.m = {1'b1, v[51:0]};
      u.e = $signed({5'b0, v[62:52]}) - 16'sd1075;
    end
    return u;
  endfunction

endpackage

// File: rtl/core/li_fpu.sv
// shared iterative double-precision add, subtract, multiply and divide unit
module li_fpu
  import li_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  fp_req_t req,
  output fp_rsp_t rsp
);

  localparam int W = 108;
  localparam logic signed [15:0] E_LSB_MIN = -16'sd1129;
  localparam logic signed [15:0] E_FLUSH   = -16'sd1237;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_ADD   = 3'd1;
  localparam logic [2:0] F_MUL   = 3'd2;
  localparam logic [2:0] F_DNORM = 3'd3;
  localparam logic [2:0] F_DIV   = 3'd4;
  localparam logic [2:0] F_NORM  = 3'd5;
  localparam logic [2:0] F_ROUND = 3'd6;
  localparam logic [2:0] F_DONE  = 3'd7;

  logic [2:0]         st_r;
  logic               sa_r, sb_r, sgn_r;
  logic signed [15:0] ea_r, eb_r, e_r;
  logic [52:0]        ma_r, mb_r;
  logic [W-1:0]       m_r;
  logic [6:0]         cnt_r;
  logic [54:0]        rem_r;
  logic [63:0]        res_r;

  // operand classification and special results
  fp_unp_t     ua, ub;
  logic        sbe, sx, spec;
  logic [63:0] spec_val;

  always_comb begin
    ua = fp_unpack(req.a);
    ub = fp_unpack(req.b);
    sbe = (req.op == FOP_SUB) ? ~ub.s : ub.s;
    sx = ua.s ^ ub.s;
    spec = 1'b1;
    spec_val = DBL_DNAN;
    if (ua.nan) begin
      spec_val = req.a | DBL_QBIT;
    end else if (ub.nan) begin
      spec_val = req.b | DBL_QBIT;
    end else begin
      unique case (req.op)
        FOP_ADD, FOP_SUB: begin
          if (ua.inf && ub.inf && (ua.s != sbe)) spec_val = DBL_DNAN;
          else if (ua.inf) spec_val = {ua.s, 11'h7FF, 52'd0};
          else if (ub.inf) spec_val = {sbe, 11'h7FF, 52'd0};
          else spec = 1'b0;
        end
        FOP_MUL: begin
          if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) spec_val = DBL_DNAN;
          else if (ua.inf || ub.inf) spec_val = {sx, 11'h7FF, 52'd0};
          else if (ua.zero || ub.zero) spec_val = {sx, 63'd0};
          else spec = 1'b0;
        end
        FOP_DIV: begin
          if ((ua.inf && ub.inf) || (ua.zero && ub.zero)) spec_val = DBL_DNAN;
          else if (ua.inf || ub.zero) spec_val = {sx, 11'h7FF, 52'd0};
          else if (ub.inf || ua.zero) spec_val = {sx, 63'd0};
          else spec = 1'b0;
        end
        default: spec = 1'b1;
      endcase
    end
  end

  // aligned add or subtract of the stored operands
  logic               a_big;
  logic signed [15:0] ebig, d;
  logic [W-1:0]       mbig, msml, sh, add_m;
  logic               sbig, ssml, add_s;

  always_comb begin
    a_big = (ea_r >= eb_r);
    ebig  = a_big ? ea_r : eb_r;
    d     = a_big ? (ea_r - eb_r) : (eb_r - ea_r);
    sbig  = a_big ? sa_r : sb_r;
    ssml  = a_big ? sb_r : sa_r;
    mbig  = {1'b0, (a_big ? ma_r : mb_r), 54'd0};
    msml  = {1'b0, (a_big ? mb_r : ma_r), 54'd0};
    if (d >= 16'sd108) begin
      sh = {{(W-1){1'b0}}, |msml};
    end else begin
      sh = (msml >> d[6:0]) | {{(W-1){1'b0}}, |(msml & ~({W{1'b1}} << d[6:0]))};
    end
    if (sbig == ssml) begin
      add_m = mbig + sh;
      add_s = sbig;
    end else if (mbig >= sh) begin
      add_m = mbig - sh;
      add_s = sbig;
    end else begin
      add_m = sh - mbig;
      add_s = ssml;
    end
    // exact cancellation rounds to +0 unless both addends are negative
    if (add_m == '0) add_s = sa_r & sb_r;
  end

  // round to nearest even and pack
  logic [52:0]        kept, kr;
  logic [53:0]        k2;
  logic               rup;
  logic signed [15:0] ee, be;
  logic [63:0]        rnd_val;

  always_comb begin
    kept = m_r[W-1:W-53];
    rup  = m_r[W-54] & ((|m_r[W-55:0]) | kept[0]);
    k2   = {1'b0, kept} + {53'd0, rup};
    if (k2[53]) begin
      kr = k2[53:1];
      ee = e_r + 16'sd1;
    end else begin
      kr = k2[52:0];
      ee = e_r;
    end
    be = kr[52] ? (ee + 16'sd1130) : 16'sd0;
    if (be >= 16'sd2047) rnd_val = {sgn_r, 11'h7FF, 52'd0};
    else rnd_val = {sgn_r, be[10:0], kr[51:0]};
  end

  logic       qbit;
  logic [54:0] rdiff;

  always_comb begin
    qbit  = (rem_r >= {2'b0, mb_r});
    rdiff = qbit ? (rem_r - {2'b0, mb_r}) : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      unique case (st_r)
        F_IDLE: begin
          if (req.go) begin
            sa_r  <= ua.s;
            sb_r  <= sbe;
            ea_r  <= ua.e;
            eb_r  <= ub.e;
            ma_r  <= ua.m;
            mb_r  <= ub.m;
            sgn_r <= sx;
            m_r   <= '0;
            if (spec) begin
              res_r <= spec_val;
              st_r  <= F_DONE;
            end else if (req.op == FOP_MUL) begin
              e_r   <= ua.e + ub.e;
              cnt_r <= 7'd53;
              st_r  <= F_MUL;
            end else if (req.op == FOP_DIV) begin
              st_r <= F_DNORM;
            end else begin
              st_r <= F_ADD;
            end
          end
        end
        F_ADD: begin
          m_r   <= add_m;
          sgn_r <= add_s;
          e_r   <= ebig - 16'sd54;
          st_r  <= F_NORM;
        end
        F_MUL: begin
          if (cnt_r == 7'd0) begin
            st_r <= F_NORM;
          end else begin
            m_r   <= {m_r[W-2:0], 1'b0} + (mb_r[52] ? {55'd0, ma_r} : '0);
            mb_r  <= {mb_r[51:0], 1'b0};
            cnt_r <= cnt_r - 7'd1;
          end
        end
        F_DNORM: begin
          if (!ma_r[52]) begin
            ma_r <= {ma_r[51:0], 1'b0};
            ea_r <= ea_r - 16'sd1;
          end else if (!mb_r[52]) begin
            mb_r <= {mb_r[51:0], 1'b0};
            eb_r <= eb_r - 16'sd1;
          end else begin
            rem_r <= {2'b0, ma_r};
            cnt_r <= 7'd56;
            e_r   <= ea_r - eb_r - 16'sd56;
            st_r  <= F_DIV;
          end
        end
        F_DIV: begin
          if (cnt_r == 7'd0) begin
            // remainder folds into a sticky bit below the quotient
            m_r  <= {m_r[W-2:0], |rem_r};
            st_r <= F_NORM;
          end else begin
            m_r   <= {m_r[W-2:0], qbit};
            rem_r <= {rdiff[53:0], 1'b0};
            cnt_r <= cnt_r - 7'd1;
          end
        end
        F_NORM: begin
          if (m_r == '0) begin
            st_r <= F_ROUND;
          end else if (e_r < E_FLUSH) begin
            m_r <= {{(W-1){1'b0}}, 1'b1};
            e_r <= E_LSB_MIN;
          end else if (e_r < E_LSB_MIN) begin
            m_r <= {1'b0, m_r[W-1:2], m_r[1] | m_r[0]};
            e_r <= e_r + 16'sd1;
          end else if (!m_r[W-1] && (e_r > E_LSB_MIN)) begin
            m_r <= {m_r[W-2:0], 1'b0};
            e_r <= e_r - 16'sd1;
          end else begin
            st_r <= F_ROUND;
          end
        end
        F_ROUND: begin
          res_r <= rnd_val;
          st_r  <= F_DONE;
        end
        F_DONE: begin
          st_r <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  assign rsp.done = (st_r == F_DONE);
  assign rsp.res  = res_r;

endmodule

// File: rtl/core/li_front.sv
// input side: takes items, drops out-of-range loads, two-entry queue to the back end
module li_front
  import li_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_func,
  input  logic [3:0]  in_point_index,
  input  logic [63:0] in_value_x,
  input  logic [63:0] in_value_y,
  input  logic        in_end_of_batch,
  output logic        q_valid,
  output li_item_t    q_item,
  input  logic        q_pop
);

  li_item_t   ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       acc, keep, deq;
  li_item_t   item;

  assign full    = (cnt_r == 2'd2);
  assign acc     = push && !full;
  assign keep    = in_func || (32'(in_point_index) < 32'(MAX_POINTS));
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rp_r];
  assign deq     = q_pop && q_valid;

  always_comb begin
    item.is_eval = in_func;
    item.slot    = in_point_index;
    item.vx      = in_value_x;
    item.vy      = in_value_y;
    item.eob     = in_end_of_batch;
  end

  always_ff @(posedge clk) begin
    if (acc && keep) ent_r[wp_r] <= item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (acc && keep) wp_r <= ~wp_r;
      if (deq) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, acc && keep} - {1'b0, deq};
    end
  end

endmodule

// File: rtl/core/li_back.sv
// back end: knot tables, evaluation sequencer around the shared unit, result register
module li_back
  import li_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        q_valid,
  input  li_item_t    q_item,
  output logic        q_pop,
  output fp_req_t     freq,
  input  fp_rsp_t     frsp,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_interpolated_value,
  output logic        out_last_result
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROWA = 4'd1;
  localparam logic [3:0] S_ROWB = 4'd2;
  localparam logic [3:0] S_COLA = 4'd3;
  localparam logic [3:0] S_COLB = 4'd4;
  localparam logic [3:0] S_NUM  = 4'd5;
  localparam logic [3:0] S_DEN  = 4'd6;
  localparam logic [3:0] S_QUO  = 4'd7;
  localparam logic [3:0] S_PROD = 4'd8;
  localparam logic [3:0] S_TERM = 4'd9;
  localparam logic [3:0] S_SUM  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [63:0] kx_mem [MAX_POINTS];
  logic [63:0] ky_mem [MAX_POINTS];
  logic [63:0] kx_rd_r, ky_rd_r;

  logic [3:0]    st_r;
  logic [4:0]    count_r;
  logic [CW-1:0] n_r, i_r, j_r, n_clamp;
  logic [63:0]   qx_r, xi_r, yi_r, xj_r, num_r, den_r, prod_r, sum_r;
  logic          eob_r, go_r;
  logic          out_valid_r, out_last_r;
  logic [63:0]   out_val_r;
  logic          mem_we, is_op, out_load;
  logic [AW-1:0] raddr, waddr;

  assign n_clamp = (32'(count_r) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(count_r);
  assign q_pop   = (st_r == S_IDLE) && q_valid;
  assign mem_we  = q_pop && !q_item.is_eval;
  assign waddr   = AW'(q_item.slot);
  assign raddr   = (st_r == S_COLA) ? j_r[AW-1:0] : i_r[AW-1:0];
  assign is_op   = (st_r == S_NUM) || (st_r == S_DEN) || (st_r == S_QUO) ||
                   (st_r == S_PROD) || (st_r == S_TERM) || (st_r == S_SUM);
  assign out_load = (st_r == S_OUT) && (!out_valid_r || pop);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      kx_mem[waddr] <= q_item.vx;
      ky_mem[waddr] <= q_item.vy;
    end
    kx_rd_r <= kx_mem[raddr];
    ky_rd_r <= ky_mem[raddr];
  end

  always_comb begin
    freq.go = is_op && !go_r;
    freq.op = FOP_SUB;
    freq.a  = qx_r;
    freq.b  = xj_r;
    unique case (st_r)
      S_DEN: begin
        freq.a = xi_r;
      end
      S_QUO: begin
        freq.op = FOP_DIV;
        freq.a  = num_r;
        freq.b  = den_r;
      end
      S_PROD: begin
        freq.op = FOP_MUL;
        freq.a  = prod_r;
        freq.b  = num_r;
      end
      S_TERM: begin
        freq.op = FOP_MUL;
        freq.a  = yi_r;
        freq.b  = prod_r;
      end
      S_SUM: begin
        freq.op = FOP_ADD;
        freq.a  = sum_r;
        freq.b  = prod_r;
      end
      default: freq.op = FOP_SUB;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      count_r     <= 5'd0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) count_r <= cfg_data;
      if (freq.go) go_r <= 1'b1;
      else if (frsp.done) go_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;

      unique case (st_r)
        S_IDLE: begin
          if (q_pop && q_item.is_eval) begin
            qx_r  <= q_item.vx;
            eob_r <= q_item.eob;
            n_r   <= n_clamp;
            sum_r <= 64'd0;
            i_r   <= '0;
            st_r  <= (n_clamp == '0) ? S_OUT : S_ROWA;
          end
        end
        S_ROWA: st_r <= S_ROWB;
        S_ROWB: begin
          xi_r   <= kx_rd_r;
          yi_r   <= ky_rd_r;
          prod_r <= DBL_ONE;
          j_r    <= '0;
          st_r   <= S_COLA;
        end
        S_COLA: begin
          if (j_r == n_r) st_r <= S_TERM;
          else if (j_r == i_r) j_r <= j_r + 1'b1;
          else st_r <= S_COLB;
        end
        S_COLB: begin
          xj_r <= kx_rd_r;
          st_r <= S_NUM;
        end
        S_NUM: begin
          if (frsp.done) begin
            num_r <= frsp.res;
            st_r  <= S_DEN;
          end
        end
        S_DEN: begin
          if (frsp.done) begin
            den_r <= frsp.res;
            st_r  <= S_QUO;
          end
        end
        S_QUO: begin
          if (frsp.done) begin
            num_r <= frsp.res;
            st_r  <= S_PROD;
          end
        end
        S_PROD: begin
          if (frsp.done) begin
            prod_r <= frsp.res;
            j_r    <= j_r + 1'b1;
            st_r   <= S_COLA;
          end
        end
        S_TERM: begin
          if (frsp.done) begin
            prod_r <= frsp.res;
            st_r   <= S_SUM;
          end
        end
        S_SUM: begin
          if (frsp.done) begin
            sum_r <= frsp.res;
            i_r   <= i_r + 1'b1;
            st_r  <= ((i_r + 1'b1) == n_r) ? S_OUT : S_ROWA;
          end
        end
        S_OUT: begin
          if (out_load) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val_r  <= sum_r;
      out_last_r <= eob_r;
    end
  end

  assign empty                  = !out_valid_r;
  assign out_interpolated_value = out_val_r;
  assign out_last_result        = out_last_r;

endmodule

// File: rtl/core/lagrange_interpolator.sv
// lagrange interpolator: load beats fill a MAX_POINTS-slot knot table (16 by default), evaluate
// beats return one double; an evaluate beat with n knots runs 4*n*(n-1)+2*n double ops through
// one shared iterative unit; n = 0 answers +0 with no double ops; one evaluate beat at a time
// the two-entry input queue and the result register let both sides stall independently
// rst_n is synchronous, active low: clears control state and point_count; knots are not cleared
module lagrange_interpolator
  import li_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_func,
  input  logic [3:0]  in_point_index,
  input  logic [63:0] in_value_x,
  input  logic [63:0] in_value_y,
  input  logic        in_end_of_batch,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_interpolated_value,
  output logic        out_last_result,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data
);

  logic     q_valid, q_pop;
  li_item_t q_item;
  fp_req_t  freq;
  fp_rsp_t  frsp;

  li_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_func         (in_func),
    .in_point_index  (in_point_index),
    .in_value_x      (in_value_x),
    .in_value_y      (in_value_y),
    .in_end_of_batch (in_end_of_batch),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  li_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_data               (cfg_data),
    .q_valid                (q_valid),
    .q_item                 (q_item),
    .q_pop                  (q_pop),
    .freq                   (freq),
    .frsp                   (frsp),
    .empty                  (empty),
    .pop                    (pop),
    .out_interpolated_value (out_interpolated_value),
    .out_last_result        (out_last_result)
  );

  li_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (freq),
    .rsp   (frsp)
  );

endmodule

// File: dv/tb_checker.sv
// watches the interpolator channels, predicts each evaluation and compares the results
module tb_checker
  import li_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic        in_func,
  input  logic [3:0]  in_point_index,
  input  logic [63:0] in_value_x,
  input  logic [63:0] in_value_y,
  input  logic        in_end_of_batch,
  input  logic        empty,
  input  logic        pop,
  input  logic [63:0] out_interpolated_value,
  input  logic        out_last_result,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] value;
    logic        last;
  } interp_result_t;

  logic [63:0]    knot_x [MAX_POINTS_DEF];
  logic [63:0]    knot_y [MAX_POINTS_DEF];
  logic [4:0]     used_points;
  interp_result_t result_fifo [$];

  // zero divisor: multiply by infinity carrying the divisor sign
  function automatic real knot_ratio(real num, real den);
    logic [63:0] inf_bits;
    if (den == 0.0) begin
      inf_bits = 64'h7FF0_0000_0000_0000 | ($realtobits(den) & 64'h8000_0000_0000_0000);
      return num * $bitstoreal(inf_bits);
    end
    return num / den;
  endfunction

  function automatic logic [63:0] lagrange_value(logic [63:0] qx_bits, int n);
    real sum, prod, qx, xi, xj, term;
    sum = 0.0;
    qx  = $bitstoreal(qx_bits);
    for (int i = 0; i < n; i++) begin
      prod = 1.0;
      xi   = $bitstoreal(knot_x[i]);
      for (int j = 0; j < n; j++) begin
        if (j != i) begin
          xj   = $bitstoreal(knot_x[j]);
          prod = prod * knot_ratio(qx - xj, xi - xj);
        end
      end
      term = $bitstoreal(knot_y[i]) * prod;
      sum  = sum + term;
    end
    return $realtobits(sum);
  endfunction

  initial begin
    fail_count  = 0;
    used_points = '0;
  end

  assign pending = result_fifo.size();

  always @(posedge clk) begin
    interp_result_t r;
    int n;
    if (!rst_n) begin
      used_points <= '0;
    end else begin
      if (cfg_we) used_points <= cfg_data;
      if (push && !full) begin
        if (!in_func) begin
          knot_x[in_point_index] = in_value_x;
          knot_y[in_point_index] = in_value_y;
        end else begin
          n = (used_points > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(used_points);
          r.value = lagrange_value(in_value_x, n);
          r.last  = in_end_of_batch;
          result_fifo.push_back(r);
        end
      end
      if (pop && !empty) begin
        if (result_fifo.size() == 0) begin
          $display("%0t unexpected result beat: got value %h last %b", $time,
                   out_interpolated_value, out_last_result);
          fail_count++;
        end else begin
          r = result_fifo.pop_front();
          if (out_interpolated_value !== r.value) begin
            $display("%0t interpolated_value mismatch: expected %h actual %h", $time,
                     r.value, out_interpolated_value);
            fail_count++;
          end
          if (out_last_result !== r.last) begin
            $display("%0t last_result mismatch: expected %b actual %b", $time,
                     r.last, out_last_result);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// File: dv/tb_top.sv
// stimulus, idling control and verdict for the lagrange interpolator
module tb_top;
  import li_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        in_func = 1'b0;
  logic [3:0]  in_point_index = '0;
  logic [63:0] in_value_x = '0;
  logic [63:0] in_value_y = '0;
  logic        in_end_of_batch = 1'b0;
  logic        pop = 1'b0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_data = '0;
  wire         full, empty, out_last_result;
  wire  [63:0] out_interpolated_value;
  int          fail_count, pending;

  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;

  always #4 clk = ~clk;

  lagrange_interpolator dut (
    .clk, .rst_n, .push, .full, .in_func, .in_point_index, .in_value_x, .in_value_y,
    .in_end_of_batch, .empty, .pop, .out_interpolated_value, .out_last_result,
    .cfg_we, .cfg_data
  );

  tb_checker chk (
    .clk, .rst_n, .push, .full, .in_func, .in_point_index, .in_value_x, .in_value_y,
    .in_end_of_batch, .empty, .pop, .out_interpolated_value, .out_last_result,
    .cfg_we, .cfg_data, .fail_count, .pending
  );

  function automatic logic [63:0] pick_double();
    case ($urandom_range(9))
      0, 1, 2, 3: return $realtobits(real'(int'($urandom_range(32)) - 16) / 4.0);
      4: case ($urandom_range(6))
           0: return 64'h0000_0000_0000_0000;
           1: return 64'h8000_0000_0000_0000;
           2: return 64'h7FF0_0000_0000_0000;
           3: return 64'hFFF0_0000_0000_0000;
           4: return 64'h7FF8_0000_0000_0000;
           5: return {32'h0000_0000, $urandom()};
           default: return 64'h7FEF_FFFF_FFFF_FFFF;
         endcase
      5, 6: return {$urandom(), $urandom()};
      default: return $realtobits((real'($urandom_range(200000)) - 100000.0) / 1000.0);
    endcase
  endfunction

  task automatic send_item(logic func, logic [3:0] idx, logic [63:0] vx, logic [63:0] vy,
                           logic eob);
    bit ok;
    if ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    push            <= 1'b1;
    in_func         <= func;
    in_point_index  <= idx;
    in_value_x      <= vx;
    in_value_y      <= vy;
    in_end_of_batch <= eob;
    forever begin
      #1 ok = !full;
      @(posedge clk);
      if (ok) break;
    end
  endtask

  task automatic set_point_count(logic [4:0] v);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_knot(logic [3:0] idx);
    logic [63:0] kx;
    kx = ($urandom_range(19) == 0) ? pick_double()
       : $realtobits(real'(idx) + real'($urandom_range(999)) / 1000.0);
    send_item(FUNC_LOAD, idx, kx, pick_double(), $urandom_range(1));
  endtask

  // receiver: random pops, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (600) @(posedge clk);
        while (hold_req) begin
          pop <= ($urandom_range(99) >= stall_pct);
          @(posedge clk);
        end
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #200_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [4:0] cnt;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every slot so no evaluation touches an unwritten knot
    for (int i = 0; i < MAX_POINTS_DEF; i++)
      send_item(FUNC_LOAD, 4'(i), $realtobits(real'(i)), $realtobits(real'(i * i) - 3.0),
                1'b0);
    set_point_count(5'd0);
    send_item(FUNC_EVAL, 4'd0, $realtobits(1.5), 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    set_point_count(5'd1);
    send_item(FUNC_EVAL, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0);
    set_point_count(5'd3);
    send_item(FUNC_EVAL, 4'd0, $realtobits(2.5), '0, 1'b1);
    send_item(FUNC_EVAL, 4'd0, 64'h0000_0000_0000_0000, '0, 1'b0);
    // duplicate knots: slot 1 gets the abscissa of slot 0
    send_item(FUNC_LOAD, 4'd1, $realtobits(0.0), $realtobits(7.0), 1'b0);
    send_item(FUNC_EVAL, 4'd0, $realtobits(0.5), '0, 1'b1);
    send_item(FUNC_EVAL, 4'd0, $realtobits(0.0), '0, 1'b0);
    send_item(FUNC_LOAD, 4'd1, $realtobits(1.0), 64'h7FF0_0000_0000_0000, 1'b1);
    send_item(FUNC_EVAL, 4'd0, 64'h8000_0000_0000_0000, '0, 1'b1);
    // count above the table size clamps to the full table
    set_point_count(5'd31);
    send_item(FUNC_EVAL, 4'd0, $realtobits(3.25), '0, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 56; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 56; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase
      case ($urandom_range(6))
        0: cnt = 5'd0;
        1: cnt = 5'd1;
        2, 3: cnt = 5'd2;
        4, 5: cnt = 5'd3;
        default: cnt = 5'd4;
      endcase
      set_point_count(cnt);
      if (ph == 4) hold_req = 1;
      for (int k = 0; k < 170; k++) begin
        if ($urandom_range(99) < 70)
          load_knot(4'($urandom_range(15)));
        else
          send_item(FUNC_EVAL, 4'($urandom_range(15)),
                    ($urandom_range(4) == 0) ? pick_double()
                      : $realtobits(real'($urandom_range(5000)) / 1000.0 - 0.5),
                    {$urandom(), $urandom()}, $urandom_range(1));
      end
      hold_req = 0;
    end

    push <= 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
